// ----- hdl/ttc_pkg.sv -----
// Shared types, constants and tables of the triangle tone channel.
package ttc_pkg;

    localparam int CMD_W       = 4;
    localparam int DATA_W      = 8;
    localparam int SAMPLE_W    = 4;
    localparam int PERIOD_W    = 11;
    localparam int LINEAR_W    = 7;
    localparam int LENGTH_W    = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = PERIOD_W;
    localparam int WAVE_STEPS_DEF = 32;

    localparam logic [PERIOD_W-1:0] FLOOR_RST   = 11'd2;
    localparam logic [PERIOD_W-1:0] CEILING_RST = 11'd2047;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FLOOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_CEILING = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 4'd0,
        CMD_QUARTER    = 4'd1,
        CMD_HALF       = 4'd2,
        CMD_WRITE_CTRL = 4'd3,
        CMD_WRITE_LO   = 4'd4,
        CMD_WRITE_HI   = 4'd5,
        CMD_ENABLE     = 4'd6,
        CMD_DISABLE    = 4'd7,
        CMD_SOFT_RESET = 4'd8
    } t_cmd;

    // Accepted item held between the input register and the channel.
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
    } t_stage;

    localparam logic [LENGTH_W-1:0] LENGTH_TABLE [32] = '{
        8'd10,  8'd254, 8'd20,  8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60,  8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24,  8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72,  8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    function automatic logic [LENGTH_W-1:0] length_load(input logic [4:0] idx);
        return LENGTH_TABLE[idx];
    endfunction

    // 32-entry triangle: 15 down to 0, then 0 up to 15.
    function automatic logic [SAMPLE_W-1:0] wave_level(input logic [4:0] idx);
        return idx[4] ? idx[3:0] : ~idx[3:0];
    endfunction

endpackage

// ----- hdl/ttc_cmd_if.sv -----
// Command channel: valid/ready handshake carrying command and data byte.
interface ttc_cmd_if;
    import ttc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data;

    modport source (output valid, output command, output data, input ready);
    modport sink   (input valid, input command, input data, output ready);
endinterface

// ----- hdl/ttc_res_if.sv -----
// Result channel: valid/ready handshake carrying sample and length status.
interface ttc_res_if;
    import ttc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                length_active;

    modport source (output valid, output sample, output length_active, input ready);
    modport sink   (input valid, input sample, input length_active, output ready);
endinterface

// ----- hdl/ttc_in_reg.sv -----
// Input register: captures one command item and holds it until the channel takes it.
module ttc_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ttc_cmd_if.sink         i_cmd,
    input  logic            i_take,
    output ttc_pkg::t_stage o_stage
);
    import ttc_pkg::*;

    logic              r_valid;
    logic [CMD_W-1:0]  r_command;
    logic [DATA_W-1:0] r_data;

    // Refill whenever empty or being drained this cycle.
    assign i_cmd.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_command <= i_cmd.command;
            r_data    <= i_cmd.data;
        end
    end

    assign o_stage = '{valid: r_valid, command: r_command, data: r_data};
endmodule

// ----- hdl/ttc_channel.sv -----
// Channel state, command decode and result register.
module ttc_channel #(
    parameter int WAVE_STEPS = ttc_pkg::WAVE_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttc_pkg::t_stage             i_stage,
    output logic                        o_take,
    input  logic                        i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ttc_res_if.source                   o_res
);
    import ttc_pkg::*;

    localparam int STEP_W = (WAVE_STEPS > 1) ? $clog2(WAVE_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WAVE_STEPS - 1);

    // Level of each sequence step, worked out at elaboration.
    logic [SAMPLE_W-1:0] level_rom [WAVE_STEPS];
    for (genvar s = 0; s < WAVE_STEPS; s++) begin : g_level
        assign level_rom[s] = wave_level(5'((s * 32) / WAVE_STEPS));
    end

    logic [PERIOD_W-1:0] r_floor, r_ceiling;
    logic [DATA_W-1:0]   r_ctrl, n_ctrl;
    logic [DATA_W-1:0]   r_period_lo, n_period_lo;
    logic [2:0]          r_period_hi, n_period_hi;
    logic [PERIOD_W-1:0] r_divider, n_divider;
    logic [LINEAR_W-1:0] r_linear, n_linear;
    logic                r_lin_reload, n_lin_reload;
    logic [LENGTH_W-1:0] r_length, n_length;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_muted, n_muted;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic                r_len_active;

    logic [PERIOD_W-1:0] cur_period, n_period;
    logic                halt;

    assign o_take     = i_stage.valid && (!r_out_valid || o_res.ready);
    assign cur_period = {r_period_hi, r_period_lo};
    assign halt       = r_ctrl[DATA_W-1];

    always_comb begin
        n_ctrl       = r_ctrl;
        n_period_lo  = r_period_lo;
        n_period_hi  = r_period_hi;
        n_divider    = r_divider;
        n_linear     = r_linear;
        n_lin_reload = r_lin_reload;
        n_length     = r_length;
        n_step       = r_step;
        n_muted      = r_muted;
        unique case (i_stage.command)
            CMD_TICK: begin
                if (r_divider == '0) begin
                    if (r_length != '0 && r_linear != '0) begin
                        n_step = (r_step == LAST_STEP) ? '0 : r_step + 1'b1;
                    end
                    n_divider = cur_period;
                end else begin
                    n_divider = r_divider - 1'b1;
                end
            end
            CMD_QUARTER: begin
                if (r_lin_reload) begin
                    n_linear = r_ctrl[LINEAR_W-1:0];
                end else if (r_linear != '0) begin
                    n_linear = r_linear - 1'b1;
                end
                if (!halt) begin
                    n_lin_reload = 1'b0;
                end
            end
            CMD_HALF: begin
                if (!halt && r_length != '0) begin
                    n_length = r_length - 1'b1;
                end
            end
            CMD_WRITE_CTRL: n_ctrl = i_stage.data;
            CMD_WRITE_LO:   n_period_lo = i_stage.data;
            CMD_WRITE_HI: begin
                n_period_hi  = i_stage.data[2:0];
                n_lin_reload = 1'b1;
                if (!r_muted) begin
                    n_length = length_load(i_stage.data[7:3]);
                end
            end
            CMD_ENABLE:  n_muted = 1'b0;
            CMD_DISABLE: begin
                n_muted  = 1'b1;
                n_length = '0;
            end
            CMD_SOFT_RESET: begin
                n_length = '0;
                n_step   = '0;
                n_muted  = 1'b1;
            end
            default: ;
        endcase

        // Result reflects the state after this item.
        n_period = {n_period_hi, n_period_lo};
        if (n_period < r_floor || n_period > r_ceiling) begin
            n_sample = '0;
        end else begin
            n_sample = level_rom[n_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor      <= FLOOR_RST;
            r_ceiling    <= CEILING_RST;
            r_ctrl       <= '0;
            r_period_lo  <= '0;
            r_period_hi  <= '0;
            r_divider    <= '0;
            r_linear     <= '0;
            r_lin_reload <= 1'b1;
            r_length     <= '0;
            r_step       <= '0;
            r_muted      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD_FLOOR:   r_floor   <= i_cfg_data;
                    CFG_PERIOD_CEILING: r_ceiling <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_take) begin
                r_ctrl       <= n_ctrl;
                r_period_lo  <= n_period_lo;
                r_period_hi  <= n_period_hi;
                r_divider    <= n_divider;
                r_linear     <= n_linear;
                r_lin_reload <= n_lin_reload;
                r_length     <= n_length;
                r_step       <= n_step;
                r_muted      <= n_muted;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sample     <= n_sample;
            r_len_active <= (n_length != '0);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.sample        = r_sample;
    assign o_res.length_active = r_len_active;
endmodule

// ----- hdl/triangle_tone_channel_core.sv -----
// Top level of the triangle tone channel.
// Triangle tone channel: every command item (period tick, quarter-frame clock, half-frame
// clock, ctrl/lo/hi register writes, enable, disable, soft reset) yields exactly one result
// item carrying the 4-bit triangle level and a length-active flag, both taken from the
// state after that command. The block takes one item per clock cycle when the result side
// keeps up. An accepted item is held in the input register, then the decode and state
// update run in a single combinational pass into the result register, from which the
// result is presented on the result channel. Back-pressure on the result side stalls
// the result register and then the input register; there is no loss. The sample is
// forced to zero when the 11-bit period lies outside [period_floor, period_ceiling].
// Write the limit registers only while the block holds no items.
module triangle_tone_channel_core #(
    parameter int WAVE_STEPS = ttc_pkg::WAVE_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ttc_cmd_if.sink                        i_cmd,
    ttc_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ttc_pkg::*;

    t_stage stage;
    logic   take;

    // Capture incoming items; hold while the channel stalls.
    ttc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (take),
        .o_stage (stage)
    );

    // Decode, advance the counters and sequence, register the result.
    ttc_channel #(
        .WAVE_STEPS (WAVE_STEPS)
    ) u_channel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .o_take     (take),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res)
    );
endmodule
